[rtl/core/bsc_pkg.sv]
// Shared constants and types for the bevel shadow color unit.
package bsc_pkg;

  localparam int CHANNEL_BITS_DEF = 16;
  localparam int FIELD_BITS       = 16;
  localparam int FRAC_BITS        = 16;

  // Q16 luma weights
  localparam logic [15:0] K_LUMA_R = 16'd19660;
  localparam logic [15:0] K_LUMA_G = 16'd38666;
  localparam logic [15:0] K_LUMA_B = 16'd7208;

  // Q16 shading factors
  localparam logic [15:0] K_DARK_BOT   = 16'd13107;
  localparam logic [15:0] K_DARK_TOP   = 16'd32768;
  localparam logic [15:0] K_LIGHT_BOT  = 16'd13107;
  localparam logic [15:0] K_LIGHT_TOP  = 16'd62259;
  localparam logic [15:0] K_FB_BASE    = 16'd39321;
  localparam logic [15:0] K_FT_BASE    = 16'd26214;
  localparam logic [15:0] K_FT_SLOPE   = 16'd19660;
  localparam int          FB_SLOPE_SH  = 14;

  typedef enum logic [1:0] {
    BAND_DARK  = 2'd0,
    BAND_MID   = 2'd1,
    BAND_LIGHT = 2'd2,
    BAND_MONO  = 2'd3
  } band_t;

endpackage

[rtl/core/bevel_shadow_color_calc_unit.sv]
// Top level of the bevel shadow color unit: stream ports, stage control and config register.
//
//  port group | dir | payload                                   | transfer when
//  in_*       | in  | tdata: base red, green, blue              | in_tvalid & in_tready
//  out_*      | out | tdata: top rgb, bottom rgb; tuser: band   | out_tvalid & out_tready
//  cfg_*      | in  | cfg_data: monochrome                      | cfg_valid & cfg_ready
//
// Eight register stages; one color per cycle while the output is not stalled.
// Each stage loads when empty or when the next one loads.
// Synchronous active-low reset clears the stage valid bits and monochrome.
// A stalled output holds; the input keeps taking colors until all stages are full.
module bevel_shadow_color_calc_unit #(
  parameter int CHANNEL_BITS = bsc_pkg::CHANNEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // base_red, base_green, base_blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // top_red, top_green, top_blue,
                                  // bottom_red, bottom_green, bottom_blue
  output logic [1:0]  out_tuser,  // brightness_band
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import bsc_pkg::*;

  localparam int CB     = CHANNEL_BITS;
  localparam int STAGES = 8;
  localparam logic [FIELD_BITS-1:0] FMAX = FIELD_BITS'((1 << CB) - 1);

  logic [STAGES-1:0]   v_r, v_nxt, en;
  logic                mono_r;
  logic [2:0][CB-1:0]  color_in, color3, color6, top, bot;
  logic                mono3;
  logic [CB-1:0]       bright3;
  band_t               band6, band8;
  logic [15:0]         fb6, ft6;

  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      mono_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
      if (cfg_valid) begin
        mono_r <= cfg_data;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      color_in[i] = in_tdata[FIELD_BITS*i +: CB];
    end
  end

  bsc_bright #(.CB(CB)) u_bright (
    .clk      (clk),
    .en       (en[2:0]),
    .mono     (mono_r),
    .color    (color_in),
    .color_o  (color3),
    .mono_o   (mono3),
    .bright_o (bright3)
  );

  bsc_factor #(.CB(CB)) u_factor (
    .clk     (clk),
    .en      (en[5:3]),
    .mono    (mono3),
    .color   (color3),
    .bright  (bright3),
    .color_o (color6),
    .band_o  (band6),
    .fb_o    (fb6),
    .ft_o    (ft6)
  );

  bsc_shade #(.CB(CB)) u_shade (
    .clk    (clk),
    .en     (en[7:6]),
    .color  (color6),
    .band   (band6),
    .fb     (fb6),
    .ft     (ft6),
    .top_o  (top),
    .bot_o  (bot),
    .band_o (band8)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_tdata[FIELD_BITS*i +: FIELD_BITS]     = FIELD_BITS'(top[i]);
      out_tdata[FIELD_BITS*(i+3) +: FIELD_BITS] = FIELD_BITS'(bot[i]);
    end
  end

  assign out_tuser  = 2'(band8);
  assign out_tvalid = v_r[STAGES-1];
  assign in_tready  = en[0];
  assign cfg_ready  = 1'b1;

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(v_r) == STAGES && !out_tready) |-> !in_tready)
    else $error("input taken while every stage is full");

  a_mono_colors: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == 2'(BAND_MONO)) |->
      (out_tdata[15:0] == FMAX && out_tdata[31:16] == FMAX && out_tdata[47:32] == FMAX &&
       out_tdata[95:48] == '0))
    else $error("monochrome result is not white over black");

  a_top_over_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] >= out_tdata[63:48] &&
                    out_tdata[31:16] >= out_tdata[79:64] &&
                    out_tdata[47:32] >= out_tdata[95:80]))
    else $error("top channel darker than bottom channel");

endmodule

[rtl/core/bsc_bright.sv]
// Brightness pipeline: luma products, channel mean and blended brightness (stages 1-3).
module bsc_bright #(
  parameter int CB = bsc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                clk,
  input  logic [2:0]          en,
  input  logic                mono,
  input  logic [2:0][CB-1:0]  color,
  output logic [2:0][CB-1:0]  color_o,
  output logic                mono_o,
  output logic [CB-1:0]       bright_o
);
  import bsc_pkg::*;

  localparam int SW = CB + 2;
  localparam int LW = CB + 16;
  localparam int DK = CB + 3;
  localparam int MW = 2 * SW;
  localparam int BW = CB + 18;
  localparam logic [SW-1:0] DIV3_M = SW'(((1 << DK) + 2) / 3);

  // stage 1
  logic [LW-1:0]         pr_r, pg_r, pb_r, pr_nxt, pg_nxt, pb_nxt;
  logic [SW-1:0]         sum3_r, sum3_nxt;
  logic [2:0][CB-1:0]    c1_r;
  logic                  m1_r;
  // stage 2
  logic [LW-1:0]         luma_r, luma_nxt;
  logic [MW-1:0]         mprod_r, mprod_nxt;
  logic [2:0][CB-1:0]    c2_r;
  logic                  m2_r;
  // stage 3
  logic [CB-1:0]         mean;
  logic [BW-1:0]         bsum;
  logic [CB-1:0]         bright_r, bright_nxt;
  logic [2:0][CB-1:0]    c3_r;
  logic                  m3_r;

  always_comb begin
    pr_nxt   = LW'(color[0]) * LW'(K_LUMA_R);
    pg_nxt   = LW'(color[1]) * LW'(K_LUMA_G);
    pb_nxt   = LW'(color[2]) * LW'(K_LUMA_B);
    sum3_nxt = SW'(color[0]) + SW'(color[1]) + SW'(color[2]);
  end

  always_comb begin
    luma_nxt  = pr_r + pg_r + pb_r;
    mprod_nxt = MW'(sum3_r) * MW'(DIV3_M);
  end

  always_comb begin
    mean       = mprod_r[DK +: CB];
    bsum       = (BW'(mean) << 14) + ((BW'(luma_r) + (BW'(luma_r) << 1)) >> 2);
    bright_nxt = bsum[FRAC_BITS +: CB];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pr_r   <= pr_nxt;
      pg_r   <= pg_nxt;
      pb_r   <= pb_nxt;
      sum3_r <= sum3_nxt;
      c1_r   <= color;
      m1_r   <= mono;
    end
    if (en[1]) begin
      luma_r  <= luma_nxt;
      mprod_r <= mprod_nxt;
      c2_r    <= c1_r;
      m2_r    <= m1_r;
    end
    if (en[2]) begin
      bright_r <= bright_nxt;
      c3_r     <= c2_r;
      m3_r     <= m2_r;
    end
  end

  assign color_o  = c3_r;
  assign mono_o   = m3_r;
  assign bright_o = bright_r;

endmodule

[rtl/core/bsc_factor.sv]
// Band decision and middle-band factors with divide-by-full-scale folding (stages 4-6).
module bsc_factor #(
  parameter int CB = bsc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                clk,
  input  logic [2:0]          en,
  input  logic                mono,
  input  logic [2:0][CB-1:0]  color,
  input  logic [CB-1:0]       bright,
  output logic [2:0][CB-1:0]  color_o,
  output bsc_pkg::band_t      band_o,
  output logic [15:0]         fb_o,
  output logic [15:0]         ft_o
);
  import bsc_pkg::*;

  localparam int CMAX = (1 << CB) - 1;
  localparam int XW   = CB + 15;
  localparam int RW   = 18;
  localparam logic [CB+6:0] DARK_LIM  = (CB+7)'(15 * CMAX);
  localparam logic [CB+1:0] LIGHT_LIM = (CB+2)'(3 * CMAX);

  // stage 4
  band_t               band_nxt, band4_r;
  logic [XW-1:0]       xb_r, xt_r, xb_nxt, xt_nxt;
  logic [2:0][CB-1:0]  c4_r;
  // stage 5
  logic [RW-1:0]       q1b_r, r1b_r, q1t_r, r1t_r;
  logic [RW-1:0]       q1b_nxt, r1b_nxt, q1t_nxt, r1t_nxt;
  band_t               band5_r;
  logic [2:0][CB-1:0]  c5_r;
  // stage 6
  logic [RW-1:0]       q2b, r2b, q2t, r2t, qb, qt;
  logic [15:0]         fb_r, ft_r, fb_nxt, ft_nxt;
  band_t               band6_r;
  logic [2:0][CB-1:0]  c6_r;

  always_comb begin
    if (mono) begin
      band_nxt = BAND_MONO;
    end else if ((CB+7)'(bright) * (CB+7)'(100) < DARK_LIM) begin
      band_nxt = BAND_DARK;
    end else if (((CB+2)'(bright) << 2) > LIGHT_LIM) begin
      band_nxt = BAND_LIGHT;
    end else begin
      band_nxt = BAND_MID;
    end
    xb_nxt = XW'(bright) << FB_SLOPE_SH;
    xt_nxt = XW'(bright) * XW'(K_FT_SLOPE);
  end

  // x / (2^CB - 1): fold high part into low part twice, then one correction
  always_comb begin
    q1b_nxt = RW'(xb_r >> CB);
    r1b_nxt = RW'(xb_r[CB-1:0]) + RW'(xb_r >> CB);
    q1t_nxt = RW'(xt_r >> CB);
    r1t_nxt = RW'(xt_r[CB-1:0]) + RW'(xt_r >> CB);
  end

  always_comb begin
    q2b    = r1b_r >> CB;
    r2b    = RW'(r1b_r[CB-1:0]) + q2b;
    qb     = q1b_r + q2b + RW'(r2b >= RW'(CMAX));
    q2t    = r1t_r >> CB;
    r2t    = RW'(r1t_r[CB-1:0]) + q2t;
    qt     = q1t_r + q2t + RW'(r2t >= RW'(CMAX));
    fb_nxt = K_FB_BASE - qb[15:0];
    ft_nxt = K_FT_BASE + qt[15:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      band4_r <= band_nxt;
      xb_r    <= xb_nxt;
      xt_r    <= xt_nxt;
      c4_r    <= color;
    end
    if (en[1]) begin
      q1b_r   <= q1b_nxt;
      r1b_r   <= r1b_nxt;
      q1t_r   <= q1t_nxt;
      r1t_r   <= r1t_nxt;
      band5_r <= band4_r;
      c5_r    <= c4_r;
    end
    if (en[2]) begin
      fb_r    <= fb_nxt;
      ft_r    <= ft_nxt;
      band6_r <= band5_r;
      c6_r    <= c5_r;
    end
  end

  assign color_o = c6_r;
  assign band_o  = band6_r;
  assign fb_o    = fb_r;
  assign ft_o    = ft_r;

endmodule

[rtl/core/bsc_shade.sv]
// Per-channel shading products and final top/bottom colors (stages 7-8).
module bsc_shade #(
  parameter int CB = bsc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                clk,
  input  logic [1:0]          en,
  input  logic [2:0][CB-1:0]  color,
  input  bsc_pkg::band_t      band,
  input  logic [15:0]         fb,
  input  logic [15:0]         ft,
  output logic [2:0][CB-1:0]  top_o,
  output logic [2:0][CB-1:0]  bot_o,
  output bsc_pkg::band_t      band_o
);
  import bsc_pkg::*;

  localparam int PW = CB + 16;
  localparam logic [CB-1:0] CMAX = CB'((1 << CB) - 1);

  // stage 7
  logic [2:0][CB-1:0]  inv, a_b, a_t;
  logic [15:0]         kb, kt;
  logic [2:0][PW-1:0]  pb_r, pt_r, pb_nxt, pt_nxt;
  logic [2:0][CB-1:0]  c7_r;
  band_t               band7_r;
  // stage 8
  logic [2:0][CB-1:0]  hb, ht;
  logic [2:0][CB-1:0]  top_r, bot_r, top_nxt, bot_nxt;
  band_t               band8_r;

  always_comb begin
    case (band)
      BAND_DARK:  begin kb = K_DARK_BOT;  kt = K_DARK_TOP;  end
      BAND_LIGHT: begin kb = K_LIGHT_BOT; kt = K_LIGHT_TOP; end
      default:    begin kb = fb;          kt = ft;          end
    endcase
    for (int i = 0; i < 3; i++) begin
      inv[i]    = CMAX - color[i];
      a_b[i]    = (band == BAND_DARK) ? inv[i] : color[i];
      a_t[i]    = (band == BAND_LIGHT) ? color[i] : inv[i];
      pb_nxt[i] = PW'(a_b[i]) * PW'(kb);
      pt_nxt[i] = PW'(a_t[i]) * PW'(kt);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hb[i] = pb_r[i][FRAC_BITS +: CB];
      ht[i] = pt_r[i][FRAC_BITS +: CB];
      case (band7_r)
        BAND_DARK: begin
          top_nxt[i] = c7_r[i] + ht[i];
          bot_nxt[i] = c7_r[i] + hb[i];
        end
        BAND_LIGHT: begin
          top_nxt[i] = ht[i];
          bot_nxt[i] = hb[i];
        end
        BAND_MID: begin
          top_nxt[i] = c7_r[i] + ht[i];
          bot_nxt[i] = c7_r[i] - hb[i];
        end
        default: begin
          top_nxt[i] = CMAX;
          bot_nxt[i] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pb_r    <= pb_nxt;
      pt_r    <= pt_nxt;
      c7_r    <= color;
      band7_r <= band;
    end
    if (en[1]) begin
      top_r   <= top_nxt;
      bot_r   <= bot_nxt;
      band8_r <= band7_r;
    end
  end

  assign top_o  = top_r;
  assign bot_o  = bot_r;
  assign band_o = band8_r;

endmodule

[bench/tb.sv]
// Self-checking testbench for the bevel shadow color unit: directed table, random colors.
`timescale 1ns / 100ps

module tb;
  import bsc_pkg::*;

  localparam logic [63:0] CH_MAX = 64'd65535;
  localparam int N_DIR = 22;
  localparam int N_PHASES = 7;
  localparam int PHASE_ITEMS = 120;
  localparam int DRAIN_CYCLES = 24;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [2:0][15:0] top;
    logic [2:0][15:0] bot;
    band_t            band;
  } shade_t;

  typedef struct packed {
    logic        mono;
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic        known;
    logic [15:0] exp_top;
    logic [15:0] exp_bot;
    band_t       exp_band;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  shade_t shade_q[$];
  shade_t pend_shade = '0;
  shade_t got_shade;
  shade_t want_shade;
  logic   mono_mode = 1'b0;
  bit     no_idle = 1'b0;
  int     err_count = 0;
  int     sink_hold = 0;
  int     idle_cycles = 0;

  stim_row_t dir_rows [N_DIR] = '{
    '{1'b0, 16'd0,     16'd0,     16'd0,     1'b1, 16'd32767, 16'd13106, BAND_DARK},
    '{1'b0, 16'd65535, 16'd65535, 16'd65535, 1'b1, 16'd62258, 16'd13106, BAND_LIGHT},
    '{1'b0, 16'd65535, 16'd0,     16'd0,     1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd0,     16'd65535, 16'd0,     1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd0,     16'd0,     16'd65535, 1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd9830,  16'd9830,  16'd9830,  1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd9831,  16'd9831,  16'd9831,  1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd9832,  16'd9832,  16'd9832,  1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd49151, 16'd49151, 16'd49151, 1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd49152, 16'd49152, 16'd49152, 1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd49153, 16'd49153, 16'd49153, 1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd49154, 16'd49154, 16'd49154, 1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd32768, 16'd32768, 16'd32768, 1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'hAAAA,  16'h5555,  16'hAAAA,  1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'h5555,  16'hAAAA,  16'h5555,  1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd1,     16'd1,     16'd1,     1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd65534, 16'd65534, 16'd65534, 1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd0,     16'd65535, 16'd65535, 1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b0, 16'd65535, 16'd65535, 16'd0,     1'b0, 16'd0, 16'd0, BAND_DARK},
    '{1'b1, 16'd0,     16'd0,     16'd0,     1'b1, 16'd65535, 16'd0, BAND_MONO},
    '{1'b1, 16'd65535, 16'd65535, 16'd65535, 1'b1, 16'd65535, 16'd0, BAND_MONO},
    '{1'b1, 16'h1234,  16'hABCD,  16'hFFFF,  1'b1, 16'd65535, 16'd0, BAND_MONO}
  };

  bevel_shadow_color_calc_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic shade_t shade_color(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                         logic mono);
    logic [63:0] c [3];
    logic [63:0] mean, luma, bright, fb, ft, t, u;
    shade_t s;
    c[0] = {48'd0, r};
    c[1] = {48'd0, g};
    c[2] = {48'd0, b};
    s = '0;
    if (mono) begin
      for (int k = 0; k < 3; k++) begin
        s.top[k] = 16'hFFFF;
        s.bot[k] = 16'h0000;
      end
      s.band = BAND_MONO;
    end else begin
      mean   = (c[0] + c[1] + c[2]) / 64'd3;
      luma   = 64'd19660 * c[0] + 64'd38666 * c[1] + 64'd7208 * c[2];
      bright = ((mean << 14) + ((64'd3 * luma) >> 2)) >> 16;
      fb     = 64'd39321 - (bright * 64'd16384) / CH_MAX;
      ft     = 64'd26214 + (bright * 64'd19660) / CH_MAX;
      if (64'd100 * bright < 64'd15 * CH_MAX) s.band = BAND_DARK;
      else if (64'd4 * bright > 64'd3 * CH_MAX) s.band = BAND_LIGHT;
      else s.band = BAND_MID;
      for (int k = 0; k < 3; k++) begin
        case (s.band)
          BAND_DARK: begin
            u = c[k] + (((CH_MAX - c[k]) * 64'd13107) >> 16);
            t = c[k] + ((CH_MAX - c[k]) >> 1);
          end
          BAND_LIGHT: begin
            u = (c[k] * 64'd13107) >> 16;
            t = (c[k] * 64'd62259) >> 16;
          end
          default: begin
            u = c[k] - ((c[k] * fb) >> 16);
            t = c[k] + (((CH_MAX - c[k]) * ft) >> 16);
          end
        endcase
        s.top[k] = t[15:0];
        s.bot[k] = u[15:0];
      end
    end
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  task automatic pick_color(output logic [15:0] r, output logic [15:0] g,
                            output logic [15:0] b);
    int kind, centre, v;
    logic [15:0] ch [3];
    kind = $urandom_range(0, 99);
    centre = ($urandom_range(0, 1) != 0) ? 9830 : 49152;
    for (int k = 0; k < 3; k++) begin
      if (kind < 55) begin
        ch[k] = 16'($urandom_range(0, 65535));
      end else if (kind < 80) begin
        v = centre + $urandom_range(0, 600) - 300;
        ch[k] = 16'(v);
      end else if (kind < 92) begin
        case ($urandom_range(0, 2))
          0: ch[k] = 16'd0;
          1: ch[k] = 16'd65535;
          default: ch[k] = 16'($urandom_range(0, 65535));
        endcase
      end else begin
        ch[k] = (k == 0) ? 16'($urandom_range(0, 65535)) : ch[0];
      end
    end
    r = ch[0];
    g = ch[1];
    b = ch[2];
  endtask

  task automatic log_mismatch(string what, int want, int got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (shade_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mono_mode = m;
  endtask

  task automatic send_color(logic [15:0] r, logic [15:0] g, logic [15:0] b, shade_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= {b, g, r};
    pend_shade <= want;
    do @(posedge clk); while (!in_tready);
  endtask

  // result check, expectation capture on input transfer, sink backpressure
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      for (int k = 0; k < 3; k++) begin
        got_shade.top[k] = out_tdata[16*k +: 16];
        got_shade.bot[k] = out_tdata[48 + 16*k +: 16];
      end
      got_shade.band = band_t'(out_tuser);
      if (shade_q.size() == 0) begin
        log_mismatch("unexpected result, band", -1, int'(got_shade.band));
      end else begin
        want_shade = shade_q.pop_front();
        for (int k = 0; k < 3; k++) begin
          if (got_shade.top[k] !== want_shade.top[k])
            log_mismatch($sformatf("top channel %0d", k), want_shade.top[k], got_shade.top[k]);
          if (got_shade.bot[k] !== want_shade.bot[k])
            log_mismatch($sformatf("bottom channel %0d", k), want_shade.bot[k],
                         got_shade.bot[k]);
        end
        if (got_shade.band !== want_shade.band)
          log_mismatch("band", int'(want_shade.band), int'(got_shade.band));
      end
    end
    if (rst_n && in_tvalid && in_tready) shade_q.push_back(pend_shade);
    if (sink_hold > 0) begin
      sink_hold--;
    end else if (no_idle || $urandom_range(0, 99) < 65) begin
      out_tready <= 1'b1;
      sink_hold = $urandom_range(1, 20);
    end else begin
      out_tready <= 1'b0;
      sink_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] r, g, b;
    shade_t want;
    logic phase_mode;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mode(1'b0);

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].mono != mono_mode) set_mode(dir_rows[i].mono);
      if (dir_rows[i].known) begin
        for (int k = 0; k < 3; k++) begin
          want.top[k] = dir_rows[i].exp_top;
          want.bot[k] = dir_rows[i].exp_bot;
        end
        want.band = dir_rows[i].exp_band;
      end else begin
        want = shade_color(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, mono_mode);
      end
      send_color(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      phase_mode = (p == 1 || p == 4);
      if (phase_mode != mono_mode) set_mode(phase_mode);
      no_idle = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_color(r, g, b);
        send_color(r, g, b, shade_color(r, g, b, mono_mode));
      end
    end
    no_idle = 1'b0;

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && shade_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[bevel_shadow_color_calc_unit.f]
rtl/core/bsc_pkg.sv
rtl/core/bsc_bright.sv
rtl/core/bsc_factor.sv
rtl/core/bsc_shade.sv
rtl/core/bevel_shadow_color_calc_unit.sv
bench/tb.sv
